@@ hdl/ple_pkg.sv @@
`timescale 1ns / 1ps
package ple_pkg;

  // Storage shape.
  localparam int CAPACITY   = 32;
  localparam int WORD_WIDTH = 32;

  // Fixed field widths of the channels.
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int ELEM_W   = 32;

  // Internal widths derived from the storage shape.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_INS_FIRST = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_LAST  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_FIRST = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_LAST  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DUMP_FWD  = 3'd6;
  localparam logic [FUNC_W-1:0] FN_DUMP_BACK = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Shift command broadcast to every storage cell.
  typedef struct packed {
    logic edit;  // apply an insert or delete this cycle
    logic ins;   // 1 insert, 0 delete
    cnt_t slot;  // 0-based slot being opened or closed
  } cell_ctrl_t;

endpackage

@@ hdl/ple_if.sv @@
`timescale 1ns / 1ps
interface ple_in_if;
  import ple_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface ple_out_if;
  import ple_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic [ELEM_W-1:0]   element;
  logic                last;

  modport source (output valid, output status, output count, output element, output last,
                  input ready);
  modport sink   (input valid, input status, input count, input element, input last,
                  output ready);
endinterface

@@ hdl/ple_cell.sv @@
`timescale 1ns / 1ps
module ple_cell (
  input  logic                      clk_i,
  input  ple_pkg::cell_ctrl_t       ctrl_i,
  input  logic [ple_pkg::IDX_W-1:0] idx_i,
  input  ple_pkg::word_t            word_i,
  input  ple_pkg::word_t            left_i,
  input  ple_pkg::word_t            right_i,
  output ple_pkg::word_t            q_o
);
  import ple_pkg::*;

  word_t data_q;
  word_t data_d;
  cnt_t  idx;

  assign idx = cnt_t'(idx_i);

  // An insert opens the slot and pushes the tail one cell toward the back;
  // a delete closes the slot and pulls the tail one cell toward the front.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.edit) begin
      if (ctrl_i.ins) begin
        if (idx == ctrl_i.slot) begin
          data_d = word_i;
        end else if (idx > ctrl_i.slot) begin
          data_d = left_i;
        end
      end else if (idx >= ctrl_i.slot) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

@@ hdl/positional_list_engine.sv @@
`timescale 1ns / 1ps
// Channel  Role  Port   Payload                          Transfer
// -------  ----  -----  -------------------------------  ---------------------
// input    sink  in_i   func, value, position            valid & ready at clk
// output   src   out_o  status, count, element, last     valid & ready at clk
//
// An insert or delete completes at the accepting edge: every cell shifts toward its
// neighbor at once and the single result is loaded into the output register.
// A dump of n elements: the accepting edge loads the read pointer, then each edge
// with a free output register loads one element through the single read port that
// walks the cells. No input is taken until the final element is loaded.
// Reset (rst_ni low, asynchronous) empties the list; cell contents are not cleared.
// A stalled output holds its result and blocks new input until the result is taken.
module positional_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  ple_in_if.sink        in_i,
  ple_out_if.source     out_o
);
  import ple_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  // Control state.
  logic             state_q, state_d;
  cnt_t             cnt_q, cnt_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic             fwd_q, fwd_d;

  // Output register.
  logic                ov_q, ov_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [ELEM_W-1:0]   elem_q, elem_d;
  logic                last_q, last_d;

  // The chain of storage cells.
  word_t      cell_q [CAPACITY];
  cell_ctrl_t ctrl;
  word_t      new_word;

  logic             out_free;
  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             dump_last;

  // The output register frees up the cycle its result is taken, so an edit can
  // follow a finished result without a bubble.
  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;

  assign new_word = word_t'(in_i.value);
  assign pos_ext  = CMP_W'(in_i.position);
  assign cnt_ext  = CMP_W'(cnt_q);

  // The walk ends at the back for a forward dump and at the front for a backward one.
  assign dump_last = fwd_q ? (cnt_t'(ptr_q) == cnt_q - cnt_t'(1)) : (ptr_q == '0);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    fwd_d    = fwd_q;
    ov_d     = ov_q && !out_o.ready;
    status_d = status_q;
    count_d  = count_q;
    elem_d   = elem_q;
    last_d   = last_q;
    ctrl     = '{edit: 1'b0, ins: 1'b0, slot: '0};

    if (accept) begin
      // Every edit gives one result with no element word and last set.
      status_d = ST_OK;
      elem_d   = '0;
      last_d   = 1'b1;
      ov_d     = 1'b1;
      case (in_i.func)
        FN_INS_FIRST, FN_INS_LAST, FN_INS_AT: begin
          // A bad position is reported ahead of a full list.
          if (in_i.func == FN_INS_AT &&
              (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
            status_d = ST_BADPOS;
          end else if (cnt_q == cnt_t'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            ctrl.edit = 1'b1;
            ctrl.ins  = 1'b1;
            if (in_i.func == FN_INS_FIRST) begin
              ctrl.slot = '0;
            end else if (in_i.func == FN_INS_LAST) begin
              ctrl.slot = cnt_q;
            end else begin
              ctrl.slot = cnt_t'(in_i.position - POS_W'(1));
            end
            cnt_d = cnt_q + cnt_t'(1);
          end
        end
        FN_DEL_FIRST, FN_DEL_LAST: begin
          if (cnt_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.edit = 1'b1;
            ctrl.slot = (in_i.func == FN_DEL_FIRST) ? '0 : cnt_q - cnt_t'(1);
            cnt_d     = cnt_q - cnt_t'(1);
          end
        end
        FN_DEL_AT: begin
          // An empty list falls under the position check here.
          if (pos_ext == '0 || pos_ext > cnt_ext) begin
            status_d = ST_BADPOS;
          end else begin
            ctrl.edit = 1'b1;
            ctrl.slot = cnt_t'(in_i.position - POS_W'(1));
            cnt_d     = cnt_q - cnt_t'(1);
          end
        end
        default: begin
          // Both dump directions.
          if (cnt_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            ov_d    = ov_q && !out_o.ready;
            state_d = S_DUMP;
            fwd_d   = (in_i.func == FN_DUMP_FWD);
            ptr_d   = (in_i.func == FN_DUMP_FWD) ? '0 : IDX_W'(cnt_q - cnt_t'(1));
          end
        end
      endcase
      count_d = COUNT_W'(cnt_d);
    end else if (state_q == S_DUMP && out_free) begin
      // One element per free output slot; the list itself is left alone.
      ov_d     = 1'b1;
      status_d = ST_OK;
      count_d  = COUNT_W'(cnt_q);
      elem_d   = ELEM_W'(cell_q[ptr_q]);
      last_d   = dump_last;
      if (dump_last) begin
        state_d = S_IDLE;
      end else if (fwd_q) begin
        ptr_d = ptr_q + IDX_W'(1);
      end else begin
        ptr_d = ptr_q - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      fwd_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      fwd_q   <= fwd_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    count_q  <= count_d;
    elem_q   <= elem_d;
    last_q   <= last_d;
  end

  // Each cell sees its two neighbors; the ends of the chain see zero.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t left_w;
    word_t right_w;

    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_body_l
      assign left_w = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_body_r
      assign right_w = cell_q[g+1];
    end

    ple_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .word_i  (new_word),
      .left_i  (left_w),
      .right_i (right_w),
      .q_o     (cell_q[g])
    );
  end

  assign out_o.valid   = ov_q;
  assign out_o.status  = status_q;
  assign out_o.count   = count_q;
  assign out_o.element = elem_q;
  assign out_o.last    = last_q;

endmodule

@@ hdl/ple_checker.sv @@
`timescale 1ns / 1ps
module ple_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [ple_pkg::FUNC_W-1:0]   in_func_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [ple_pkg::STATUS_W-1:0] out_status_i,
  input logic [ple_pkg::COUNT_W-1:0]  out_count_i,
  input logic [ple_pkg::ELEM_W-1:0]   out_element_i,
  input logic                         out_last_i
);
  import ple_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_count_i) && $stable(out_element_i) && $stable(out_last_i))
    else $error("output result changed while stalled");

  // No new input is taken while a result waits.
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  // An edit answers on the next cycle with a single, final, empty-word result.
  a_edit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i != FN_DUMP_FWD && in_func_i != FN_DUMP_BACK
    |=> out_valid_i && out_last_i && out_element_i == '0)
    else $error("edit result missing or malformed");

  // Any error status ends the item's results.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_last_i)
    else $error("error status on a non-final result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i <= CAPACITY)
    else $error("count beyond capacity");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_count_i   (out_o.count),
  .out_element_i (out_o.element),
  .out_last_i    (out_o.last)
);

@@ tb/sv/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps
module tb_positional_list_engine;
  import ple_pkg::*;

  // One result as it appears on the output channel.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [ELEM_W-1:0]   element;
    logic                last;
  } list_result_t;

  // One row of the directed table. Where typed is set, the expected single result is
  // written out in the row. Otherwise the shadow list supplies the expected results.
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } list_row_t;

  // The random part runs in three phases: the list is grown until full, drained until
  // empty, and then hit with an even mix of operations.
  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} list_phase_e;

  localparam int NUM_ROWS  = 24;
  localparam int TAIL_CYCLES = 20;

  logic clk;
  logic rst_n;

  ple_in_if  in_ch();
  ple_out_if out_ch();

  positional_list_engine uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the list. Slot 0 is the front.
  word_t        shadow_words [CAPACITY];
  int unsigned  shadow_n;

  // Results that one operation produces, and the results still owed by the block.
  list_result_t op_results [$];
  list_result_t expected_results [$];

  list_row_t    directed_rows [NUM_ROWS];
  int unsigned  err_count;
  bit           idle_on  = 1'b1;
  bit           stall_on = 1'b1;

  // The clock has a period of 10 ns.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Open a slot at idx by shifting every element from idx on one place toward the back.
  function automatic void open_slot(input int unsigned idx, input word_t w);
    for (int unsigned i = shadow_n; i > idx; i--) begin
      shadow_words[i] = shadow_words[i-1];
    end
    shadow_words[idx] = w;
    shadow_n++;
  endfunction

  // Close the slot at idx by shifting every later element one place toward the front.
  function automatic void close_slot(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < shadow_n; i++) begin
      shadow_words[i] = shadow_words[i+1];
    end
    shadow_n--;
  endfunction

  function automatic list_result_t make_result(input logic [STATUS_W-1:0] st,
                                               input word_t elem, input logic lst);
    list_result_t r;
    r.status  = st;
    r.count   = COUNT_W'(shadow_n);
    r.element = ELEM_W'(elem);
    r.last    = lst;
    return r;
  endfunction

  // Apply one operation to the shadow list and leave its results in op_results.
  // The position check of a positional insert comes before the fullness check, and a
  // positional delete on an empty list reports a bad position rather than an empty list.
  function automatic void predict_list_op(input logic [FUNC_W-1:0] f, input word_t v,
                                          input int unsigned p);
    logic [STATUS_W-1:0] st;
    int unsigned         idx;
    st = ST_OK;
    op_results.delete();
    case (f)
      FN_INS_FIRST, FN_INS_LAST, FN_INS_AT: begin
        if (f == FN_INS_AT && (p < 1 || p > shadow_n + 1)) st = ST_BADPOS;
        else if (shadow_n >= CAPACITY) st = ST_FULL;
        else if (f == FN_INS_FIRST) open_slot(0, v);
        else if (f == FN_INS_LAST) open_slot(shadow_n, v);
        else open_slot(p - 1, v);
      end
      FN_DEL_FIRST, FN_DEL_LAST: begin
        if (shadow_n == 0) st = ST_EMPTY;
        else close_slot((f == FN_DEL_FIRST) ? 0 : shadow_n - 1);
      end
      FN_DEL_AT: begin
        if (p < 1 || p > shadow_n) st = ST_BADPOS;
        else close_slot(p - 1);
      end
      default: begin
        // A dump of a non-empty list gives one result per element, last on the final one.
        if (shadow_n == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < shadow_n; i++) begin
            idx = (f == FN_DUMP_FWD) ? i : shadow_n - 1 - i;
            op_results.push_back(make_result(ST_OK, shadow_words[idx], i + 1 == shadow_n));
          end
          return;
        end
      end
    endcase
    op_results.push_back(make_result(st, '0, 1'b1));
  endfunction

  // Present one operation, wait for its transfer, and record the results it owes.
  // A random idle burst may come first while idle_on is set.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                           input logic [POS_W-1:0] p, input logic typed,
                           input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] cnt);
    list_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.value    <= v;
    in_ch.position <= p;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    predict_list_op(f, v, p);
    if (typed) begin
      r.status  = st;
      r.count   = cnt;
      r.element = '0;
      r.last    = 1'b1;
      expected_results.push_back(r);
    end else begin
      foreach (op_results[i]) expected_results.push_back(op_results[i]);
    end
  endtask

  // Hold the input channel idle until every owed result has been taken.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Pick one random operation. Positions are mostly legal for the current length,
  // values lean toward all zeros and all ones now and then.
  task automatic send_random_op(input list_phase_e ph);
    int unsigned         w;
    logic [FUNC_W-1:0]   f;
    logic [VALUE_W-1:0]  v;
    logic [POS_W-1:0]    p;
    w = $urandom_range(0, 99);
    case (ph)
      PH_GROW: begin
        if (w < 85) f = FUNC_W'($urandom_range(FN_INS_FIRST, FN_INS_AT));
        else if (w < 92) f = FUNC_W'($urandom_range(FN_DEL_FIRST, FN_DEL_AT));
        else f = FUNC_W'($urandom_range(FN_DUMP_FWD, FN_DUMP_BACK));
      end
      PH_SHRINK: begin
        if (w < 80) f = FUNC_W'($urandom_range(FN_DEL_FIRST, FN_DEL_AT));
        else if (w < 88) f = FUNC_W'($urandom_range(FN_INS_FIRST, FN_INS_AT));
        else f = FUNC_W'($urandom_range(FN_DUMP_FWD, FN_DUMP_BACK));
      end
      default: f = FUNC_W'($urandom_range(FN_INS_FIRST, FN_DUMP_BACK));
    endcase
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 4) == 0) p = POS_W'($urandom_range(0, 63));
    else if (f == FN_INS_AT) p = POS_W'($urandom_range(1, shadow_n + 1));
    else if (f == FN_DEL_AT && shadow_n > 0) p = POS_W'($urandom_range(1, shadow_n));
    else p = POS_W'($urandom_range(0, 63));
    send_item(f, v, p, 1'b0, ST_OK, '0);
  endtask

  // Output side: ready drops in random bursts while stall_on is set.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest owed result, field by field.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status  = out_ch.status;
      got.count   = out_ch.count;
      got.element = out_ch.element;
      got.last    = out_ch.last;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none owed: status %0d count %0d elem %h",
                                  got.status, got.count, got.element));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.count !== want.count)
          report_mismatch($sformatf("count %0d, wanted %0d", got.count, want.count));
        if (got.element !== want.element)
          report_mismatch($sformatf("element %h, wanted %h", got.element, want.element));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
      end
    end
  end

  // Stimulus and the end of the run.
  initial begin
    int unsigned extra;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FN_INS_FIRST;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    err_count = 0;
    shadow_n  = 0;

    // Directed part. The first rows work on the empty list just after reset, then the
    // list is built through every kind of insert, dumped both ways, and trimmed with
    // deletes at the ends, in the middle and at positions out of range.
    directed_rows = '{
      '{FN_DEL_FIRST, 32'h0,        6'd0,  1'b1, ST_EMPTY,  6'd0},
      '{FN_DEL_LAST,  32'h0,        6'd0,  1'b1, ST_EMPTY,  6'd0},
      '{FN_DEL_AT,    32'h0,        6'd1,  1'b1, ST_BADPOS, 6'd0},
      '{FN_DUMP_FWD,  32'h0,        6'd0,  1'b1, ST_EMPTY,  6'd0},
      '{FN_DUMP_BACK, 32'h0,        6'd0,  1'b1, ST_EMPTY,  6'd0},
      '{FN_INS_AT,    32'h1234,     6'd0,  1'b1, ST_BADPOS, 6'd0},
      '{FN_INS_AT,    32'h1234,     6'd2,  1'b1, ST_BADPOS, 6'd0},
      '{FN_INS_AT,    32'hFFFFFFFF, 6'd1,  1'b1, ST_OK,     6'd1},
      '{FN_INS_FIRST, 32'h0,        6'd63, 1'b1, ST_OK,     6'd2},
      '{FN_INS_LAST,  32'hA5A5A5A5, 6'd0,  1'b1, ST_OK,     6'd3},
      '{FN_INS_AT,    32'h5A5A5A5A, 6'd4,  1'b1, ST_OK,     6'd4},
      '{FN_INS_AT,    32'h80000001, 6'd2,  1'b1, ST_OK,     6'd5},
      '{FN_DUMP_FWD,  32'h0,        6'd0,  1'b0, ST_OK,     6'd0},
      '{FN_DUMP_BACK, 32'hFFFFFFFF, 6'd63, 1'b0, ST_OK,     6'd0},
      '{FN_INS_AT,    32'h3C3C3C3C, 6'd63, 1'b1, ST_BADPOS, 6'd5},
      '{FN_DEL_AT,    32'h0,        6'd63, 1'b1, ST_BADPOS, 6'd5},
      '{FN_DEL_AT,    32'h0,        6'd0,  1'b1, ST_BADPOS, 6'd5},
      '{FN_DEL_AT,    32'h0,        6'd5,  1'b1, ST_OK,     6'd4},
      '{FN_DEL_AT,    32'h0,        6'd2,  1'b1, ST_OK,     6'd3},
      '{FN_INS_AT,    32'h0F0F0F0F, 6'd3,  1'b0, ST_OK,     6'd0},
      '{FN_DUMP_FWD,  32'h0,        6'd0,  1'b0, ST_OK,     6'd0},
      '{FN_DEL_FIRST, 32'h0,        6'd0,  1'b1, ST_OK,     6'd3},
      '{FN_DEL_LAST,  32'h0,        6'd0,  1'b1, ST_OK,     6'd2},
      '{FN_DUMP_BACK, 32'h0,        6'd0,  1'b0, ST_OK,     6'd0}
    };

    // Reset is held low from the start and released on a rising edge.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].position,
                directed_rows[i].typed, directed_rows[i].status, directed_rows[i].count);
    end
    wait_for_drain();

    // Grow until the list is full and keep pushing a while, so that full-list inserts,
    // bad positions on a full list and full-length dumps all occur.
    extra = 0;
    while (extra < 8) begin
      send_random_op(PH_GROW);
      if (shadow_n == CAPACITY) extra++;
    end
    wait_for_drain();

    // Drain to empty and go on deleting, so that empty-list deletes and dumps occur.
    extra = 0;
    while (extra < 6) begin
      send_random_op(PH_SHRINK);
      if (shadow_n == 0) extra++;
    end

    // Last stretch: an even mix of operations with both sides running flat out.
    idle_on  = 1'b0;
    stall_on = 1'b0;
    repeat (16) send_random_op(PH_MIXED);

    // Wait for every owed result, then keep watching the output to catch any stray one.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a correct run is far shorter than this, even with every stall at its longest.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
